// ----- hw/rtl/lfos_pkg.sv -----
package lfos_pkg;

  // Mode codes, as reported on the mode field of each result beat
  localparam logic [3:0] MODE_FOLLOW   = 4'd0;
  localparam logic [3:0] MODE_STOP     = 4'd1;
  localparam logic [3:0] MODE_TURN_R   = 4'd2;
  localparam logic [3:0] MODE_OUT      = 4'd3;
  localparam logic [3:0] MODE_TURN_L1  = 4'd4;
  localparam logic [3:0] MODE_PAST     = 4'd5;
  localparam logic [3:0] MODE_TURN_L2  = 4'd6;
  localparam logic [3:0] MODE_IN       = 4'd7;
  localparam logic [3:0] MODE_ALIGN    = 4'd8;

  // Last side on which the line was seen
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LINE_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_BASE_SPEED     = 3'd1;
  localparam logic [2:0] CFG_TURN_SPEED     = 3'd2;
  localparam logic [2:0] CFG_TURN_TIME_MS   = 3'd3;
  localparam logic [2:0] CFG_DRIVE_OUT_MS   = 3'd4;
  localparam logic [2:0] CFG_DRIVE_PAST_MS  = 3'd5;
  localparam logic [2:0] CFG_DRIVE_IN_MS    = 3'd6;
  localparam logic [2:0] CFG_ECHO_MAX_US    = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Fixed timing and limits
  localparam logic [14:0] PWM_TOP        = 15'd25000;
  localparam logic [31:0] PING_PERIOD_MS = 32'd60;
  localparam logic [31:0] STOP_HOLD_MS   = 32'd1000;
  localparam logic [15:0] ECHO_MIN_US    = 16'd117;

  // Register reset values
  localparam logic [11:0] RST_LINE_THRESHOLD = 12'd1100;
  localparam logic [14:0] RST_BASE_SPEED     = 15'd16500;
  localparam logic [14:0] RST_TURN_SPEED     = 15'd16000;
  localparam logic [15:0] RST_TURN_TIME_MS   = 16'd650;
  localparam logic [15:0] RST_DRIVE_OUT_MS   = 16'd800;
  localparam logic [15:0] RST_DRIVE_PAST_MS  = 16'd1800;
  localparam logic [15:0] RST_DRIVE_IN_MS    = 16'd800;
  localparam logic [15:0] RST_ECHO_MAX_US    = 16'd874;

  // Clamp a duty to the PWM period
  function automatic logic [14:0] clamp_duty(input logic [14:0] d);
    clamp_duty = (d > PWM_TOP) ? PWM_TOP : d;
  endfunction

endpackage

// ----- hw/rtl/lfos_in_if.sv -----
interface lfos_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [11:0] left_level;
  logic [11:0] right_level;
  logic        echo_valid;
  logic [15:0] echo_us;

  modport source (
    output valid, time_ms, left_level, right_level, echo_valid, echo_us,
    input  ready
  );
  modport sink (
    input  valid, time_ms, left_level, right_level, echo_valid, echo_us,
    output ready
  );
endinterface

// ----- hw/rtl/lfos_out_if.sv -----
interface lfos_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] left_duty;
  logic [14:0] right_duty;
  logic        trigger;
  logic [3:0]  mode;

  modport source (
    output valid, left_duty, right_duty, trigger, mode,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, trigger, mode,
    output ready
  );
endinterface

// ----- hw/rtl/line_follow_obstacle_sequencer.sv -----
// Channel   | Dir | Handshake     | Beat contents
// ----------+-----+---------------+----------------------------------------------
// in_i      | in  | valid/ready   | time_ms, left_level, right_level, echo_valid,
//           |     |               | echo_us
// out_o     | out | valid/ready   | left_duty, right_duty, trigger, mode
// cfg       | in  | cfg_we_i      | cfg_idx_i selects register, cfg_data_i value
//
// One beat per cycle if out_o keeps up; result valid the cycle after acceptance.
// All tick logic (ping timer, mode sequencer, duty select) runs in the accept
// cycle and lands in the state and result registers together.
// in_i.ready is high when the result register is empty or being drained.
// Reset (rst_ni, asynchronous, active low) clears the state, loads register
// defaults and empties the result register.
module line_follow_obstacle_sequencer import lfos_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lfos_in_if.sink             in_i,
  lfos_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [11:0] line_thr_q;
  logic [14:0] base_speed_q, turn_speed_q;
  logic [15:0] turn_ms_q, out_ms_q, past_ms_q, in_ms_q, echo_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_thr_q   <= RST_LINE_THRESHOLD;
      base_speed_q <= RST_BASE_SPEED;
      turn_speed_q <= RST_TURN_SPEED;
      turn_ms_q    <= RST_TURN_TIME_MS;
      out_ms_q     <= RST_DRIVE_OUT_MS;
      past_ms_q    <= RST_DRIVE_PAST_MS;
      in_ms_q      <= RST_DRIVE_IN_MS;
      echo_max_q   <= RST_ECHO_MAX_US;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_THRESHOLD: line_thr_q   <= cfg_data_i[11:0];
        CFG_BASE_SPEED:     base_speed_q <= cfg_data_i[14:0];
        CFG_TURN_SPEED:     turn_speed_q <= cfg_data_i[14:0];
        CFG_TURN_TIME_MS:   turn_ms_q    <= cfg_data_i;
        CFG_DRIVE_OUT_MS:   out_ms_q     <= cfg_data_i;
        CFG_DRIVE_PAST_MS:  past_ms_q    <= cfg_data_i;
        CFG_DRIVE_IN_MS:    in_ms_q      <= cfg_data_i;
        CFG_ECHO_MAX_US:    echo_max_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: result register doubles as the stage boundary
  logic out_valid_q;
  logic acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  // Sequencer state
  logic [3:0]  mode_q, mode_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] ping_q;
  logic [1:0]  side_q, side_d;
  logic [14:0] ldut_q, ldut_d, rdut_q, rdut_d;
  logic        trig_q, trig_d;

  logic [31:0] elapsed, since_ping;
  logic        lb, rb, obstacle;
  logic [14:0] base_c, turn_c;
  logic        t_turn, t_out, t_past, t_in, t_stop;

  assign lb         = in_i.left_level > line_thr_q;
  assign rb         = in_i.right_level > line_thr_q;
  assign elapsed    = in_i.time_ms - entry_q;
  assign since_ping = in_i.time_ms - ping_q;
  assign trig_d     = since_ping > PING_PERIOD_MS;
  assign obstacle   = in_i.echo_valid && (in_i.echo_us >= ECHO_MIN_US)
                      && (in_i.echo_us <= echo_max_q);
  assign base_c     = clamp_duty(base_speed_q);
  assign turn_c     = clamp_duty(turn_speed_q);

  // Phase timeouts, strictly greater than the set time
  assign t_stop = elapsed > STOP_HOLD_MS;
  assign t_turn = elapsed > {16'd0, turn_ms_q};
  assign t_out  = elapsed > {16'd0, out_ms_q};
  assign t_past = elapsed > {16'd0, past_ms_q};
  assign t_in   = elapsed > {16'd0, in_ms_q};

  // Next state and duties for one tick
  always_comb begin
    mode_d  = mode_q;
    entry_d = entry_q;
    side_d  = side_q;
    ldut_d  = ldut_q;
    rdut_d  = rdut_q;
    case (mode_q)
      MODE_STOP: begin
        if (t_stop) begin
          mode_d  = MODE_TURN_R;
          entry_d = in_i.time_ms;
        end
      end
      MODE_TURN_R: begin
        ldut_d = turn_c;
        rdut_d = '0;
        if (t_turn) begin
          mode_d  = MODE_OUT;
          entry_d = in_i.time_ms;
        end
      end
      MODE_OUT: begin
        ldut_d = base_c;
        rdut_d = base_c;
        if (t_out) begin
          mode_d  = MODE_TURN_L1;
          entry_d = in_i.time_ms;
        end
      end
      MODE_TURN_L1: begin
        ldut_d = '0;
        rdut_d = turn_c;
        if (t_turn) begin
          mode_d  = MODE_PAST;
          entry_d = in_i.time_ms;
        end
      end
      MODE_PAST: begin
        ldut_d = base_c;
        rdut_d = base_c;
        if (t_past) begin
          mode_d  = MODE_TURN_L2;
          entry_d = in_i.time_ms;
        end
      end
      MODE_TURN_L2: begin
        ldut_d = '0;
        rdut_d = turn_c;
        if (t_turn) begin
          mode_d  = MODE_IN;
          entry_d = in_i.time_ms;
        end
      end
      MODE_IN: begin
        ldut_d = base_c;
        rdut_d = base_c;
        // timeout wins over a line hit on the same tick
        if (t_in) begin
          mode_d  = MODE_ALIGN;
          entry_d = in_i.time_ms;
        end else if (lb || rb) begin
          mode_d = MODE_FOLLOW;
        end
      end
      MODE_ALIGN: begin
        ldut_d = turn_c;
        rdut_d = '0;
        if (lb || rb || t_turn) mode_d = MODE_FOLLOW;
      end
      default: begin
        // line following; unused codes land here too
        mode_d = MODE_FOLLOW;
        if (obstacle) begin
          mode_d  = MODE_STOP;
          entry_d = in_i.time_ms;
          ldut_d  = '0;
          rdut_d  = '0;
        end else if (lb && rb) begin
          ldut_d = base_c;
          rdut_d = base_c;
        end else if (lb) begin
          side_d = SIDE_LEFT;
          ldut_d = '0;
          rdut_d = turn_c;
        end else if (rb) begin
          side_d = SIDE_RIGHT;
          ldut_d = turn_c;
          rdut_d = '0;
        end else if (side_q == SIDE_LEFT) begin
          ldut_d = '0;
          rdut_d = turn_c;
        end else if (side_q == SIDE_RIGHT) begin
          ldut_d = turn_c;
          rdut_d = '0;
        end else begin
          ldut_d = base_c;
          rdut_d = base_c;
        end
      end
    endcase
  end

  // State and result registers, loaded on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FOLLOW;
      entry_q     <= '0;
      ping_q      <= '0;
      side_q      <= SIDE_NONE;
      ldut_q      <= '0;
      rdut_q      <= '0;
      trig_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        mode_q  <= mode_d;
        entry_q <= entry_d;
        side_q  <= side_d;
        ldut_q  <= ldut_d;
        rdut_q  <= rdut_d;
        trig_q  <= trig_d;
        if (trig_d) ping_q <= in_i.time_ms;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.left_duty  = ldut_q;
  assign out_o.right_duty = rdut_q;
  assign out_o.trigger    = trig_q;
  assign out_o.mode       = mode_q;

`ifndef SYNTHESIS
  // duties never leave the PWM range
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ldut_q <= PWM_TOP) && (rdut_q <= PWM_TOP))
    else $error("duty above PWM top");

  // only defined mode codes are ever stored
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_ALIGN)
    else $error("mode code out of range");

  // motors stand still through the stop phase
  a_stop_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STOP) |-> (ldut_q == '0) && (rdut_q == '0))
    else $error("motor driven while stopped");

  // an accepted beat always leaves a result waiting
  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted beat produced no result");

  // a trigger restamps the ping timer with that tick's time
  a_ping_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && trig_d) |=> (ping_q == $past(in_i.time_ms)) && trig_q)
    else $error("ping timer not restamped");
`endif

endmodule

// ----- bench/lfos_tick_checker.sv -----
module lfos_tick_checker import lfos_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lfos_in_if                  in_mon,
  lfos_out_if                 out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         fail_cnt_o
);

  typedef struct packed {
    logic [14:0] left_duty;
    logic [14:0] right_duty;
    logic        trigger;
    logic [3:0]  mode;
  } drive_beat_t;

  // Shadow of the configuration registers
  logic [11:0] thr_q;
  logic [14:0] base_q;
  logic [14:0] turnspd_q;
  logic [15:0] turn_ms_q;
  logic [15:0] out_ms_q;
  logic [15:0] past_ms_q;
  logic [15:0] in_ms_q;
  logic [15:0] echo_max_q;

  // Shadow of the sequencer state
  logic [3:0]  mode_q;
  logic [31:0] entry_ms;
  logic [31:0] ping_ms;
  logic [1:0]  side_q;
  logic [14:0] lduty_q;
  logic [14:0] rduty_q;

  // Expected drive beats, oldest first
  drive_beat_t drive_q[$];
  int unsigned mismatches;

  // Duties saturate at the PWM period
  function automatic void drive_wheels(logic [14:0] l, logic [14:0] r);
    lduty_q = (l > PWM_TOP) ? PWM_TOP : l;
    rduty_q = (r > PWM_TOP) ? PWM_TOP : r;
  endfunction

  function automatic void enter_mode(logic [3:0] m, logic [31:0] now);
    mode_q   = m;
    entry_ms = now;
  endfunction

  // One control tick: ping timer, detour sequencer, line steering
  function automatic drive_beat_t control_tick(logic [31:0] now, logic [11:0] lv,
                                               logic [11:0] rv, logic ev,
                                               logic [15:0] eus);
    logic        lb;
    logic        rb;
    logic [31:0] elapsed;
    drive_beat_t res;
    lb          = lv > thr_q;
    rb          = rv > thr_q;
    elapsed     = now - entry_ms;
    res.trigger = 1'b0;
    if ((now - ping_ms) > PING_PERIOD_MS) begin
      res.trigger = 1'b1;
      ping_ms     = now;
    end
    case (mode_q)
      MODE_STOP: begin
        if (elapsed > STOP_HOLD_MS) enter_mode(MODE_TURN_R, now);
      end
      MODE_TURN_R: begin
        drive_wheels(turnspd_q, 15'd0);
        if (elapsed > {16'd0, turn_ms_q}) enter_mode(MODE_OUT, now);
      end
      MODE_OUT: begin
        drive_wheels(base_q, base_q);
        if (elapsed > {16'd0, out_ms_q}) enter_mode(MODE_TURN_L1, now);
      end
      MODE_TURN_L1: begin
        drive_wheels(15'd0, turnspd_q);
        if (elapsed > {16'd0, turn_ms_q}) enter_mode(MODE_PAST, now);
      end
      MODE_PAST: begin
        drive_wheels(base_q, base_q);
        if (elapsed > {16'd0, past_ms_q}) enter_mode(MODE_TURN_L2, now);
      end
      MODE_TURN_L2: begin
        drive_wheels(15'd0, turnspd_q);
        if (elapsed > {16'd0, turn_ms_q}) enter_mode(MODE_IN, now);
      end
      MODE_IN: begin
        drive_wheels(base_q, base_q);
        // timeout wins over a line hit on the same tick
        if (lb || rb) mode_q = MODE_FOLLOW;
        if (elapsed > {16'd0, in_ms_q}) enter_mode(MODE_ALIGN, now);
      end
      MODE_ALIGN: begin
        drive_wheels(turnspd_q, 15'd0);
        if (lb || rb || elapsed > {16'd0, turn_ms_q}) mode_q = MODE_FOLLOW;
      end
      default: begin
        mode_q = MODE_FOLLOW;
        if (ev && eus >= ECHO_MIN_US && eus <= echo_max_q) begin
          enter_mode(MODE_STOP, now);
          drive_wheels(15'd0, 15'd0);
        end else if (lb && rb) begin
          drive_wheels(base_q, base_q);
        end else if (lb) begin
          side_q = SIDE_LEFT;
          drive_wheels(15'd0, turnspd_q);
        end else if (rb) begin
          side_q = SIDE_RIGHT;
          drive_wheels(turnspd_q, 15'd0);
        end else if (side_q == SIDE_LEFT) begin
          drive_wheels(15'd0, turnspd_q);
        end else if (side_q == SIDE_RIGHT) begin
          drive_wheels(turnspd_q, 15'd0);
        end else begin
          drive_wheels(base_q, base_q);
        end
      end
    endcase
    res.left_duty  = lduty_q;
    res.right_duty = rduty_q;
    res.mode       = mode_q;
    return res;
  endfunction

  function automatic int unsigned check_field(string name, int unsigned want,
                                              int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch config writes, result beats and input beats at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    drive_beat_t got;
    drive_beat_t want;
    if (!rst_ni) begin
      thr_q      = RST_LINE_THRESHOLD;
      base_q     = RST_BASE_SPEED;
      turnspd_q  = RST_TURN_SPEED;
      turn_ms_q  = RST_TURN_TIME_MS;
      out_ms_q   = RST_DRIVE_OUT_MS;
      past_ms_q  = RST_DRIVE_PAST_MS;
      in_ms_q    = RST_DRIVE_IN_MS;
      echo_max_q = RST_ECHO_MAX_US;
      mode_q     = MODE_FOLLOW;
      entry_ms   = '0;
      ping_ms    = '0;
      side_q     = SIDE_NONE;
      lduty_q    = '0;
      rduty_q    = '0;
      drive_q.delete();
      mismatches = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINE_THRESHOLD: thr_q      = cfg_data_i[11:0];
          CFG_BASE_SPEED:     base_q     = cfg_data_i[14:0];
          CFG_TURN_SPEED:     turnspd_q  = cfg_data_i[14:0];
          CFG_TURN_TIME_MS:   turn_ms_q  = cfg_data_i;
          CFG_DRIVE_OUT_MS:   out_ms_q   = cfg_data_i;
          CFG_DRIVE_PAST_MS:  past_ms_q  = cfg_data_i;
          CFG_DRIVE_IN_MS:    in_ms_q    = cfg_data_i;
          CFG_ECHO_MAX_US:    echo_max_q = cfg_data_i;
          default: ;
        endcase
      end
      // result beat: compare with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got.left_duty  = out_mon.left_duty;
        got.right_duty = out_mon.right_duty;
        got.trigger    = out_mon.trigger;
        got.mode       = out_mon.mode;
        if (drive_q.size() == 0) begin
          $error("result beat with no expectation pending");
          mismatches++;
        end else begin
          want = drive_q.pop_front();
          mismatches += check_field("left_duty", 32'(want.left_duty),
                                    32'(got.left_duty));
          mismatches += check_field("right_duty", 32'(want.right_duty),
                                    32'(got.right_duty));
          mismatches += check_field("trigger", 32'(want.trigger),
                                    32'(got.trigger));
          mismatches += check_field("mode", 32'(want.mode), 32'(got.mode));
        end
      end
      // input beat: run the tick
      if (in_mon.valid && in_mon.ready) begin
        drive_q.push_back(control_tick(in_mon.time_ms, in_mon.left_level,
                                       in_mon.right_level, in_mon.echo_valid,
                                       in_mon.echo_us));
      end
      pending_o  <= drive_q.size();
      fail_cnt_o <= mismatches;
    end
  end

endmodule

// ----- bench/tb_line_follow_obstacle_sequencer.sv -----
module tb_line_follow_obstacle_sequencer;
  import lfos_pkg::*;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [11:0] left_level;
    logic [11:0] right_level;
    logic        echo_valid;
    logic [15:0] echo_us;
  } tick_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseTicks = 105;
  localparam int unsigned NumPhases  = 5;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int unsigned         pending;
  int unsigned         fail_cnt;
  int unsigned         cycle_cnt = 0;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  logic [31:0] now_ms;
  logic [15:0] cfg_val [8];

  lfos_in_if  in_ch ();
  lfos_out_if out_ch ();

  line_follow_obstacle_sequencer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  lfos_tick_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  always #6 clk_i = ~clk_i;

  // Result side back-pressure
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("line_follow_obstacle_sequencer verification failed");
    $finish;
  end

  // Offer one tick beat, with random gaps ahead of it
  task automatic send_tick(input tick_t t);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.time_ms     <= t.time_ms;
    in_ch.left_level  <= t.left_level;
    in_ch.right_level <= t.right_level;
    in_ch.echo_valid  <= t.echo_valid;
    in_ch.echo_us     <= t.echo_us;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_fields(input logic [31:0] tm, input logic [11:0] lv,
                             input logic [11:0] rv, input logic ev,
                             input logic [15:0] eus);
    tick_t t;
    t = '{tm, lv, rv, ev, eus};
    now_ms = tm;
    send_tick(t);
  endtask

  // Hold the input idle until every expected beat has come back
  task automatic drain_ticks();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= cfg_val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Sensor level: full range, near the threshold, or a rail
  function automatic logic [11:0] roll_level();
    int unsigned r;
    int          lvl;
    r = $urandom_range(0, 9);
    if (r < 4) return 12'($urandom_range(0, 4095));
    if (r < 8) begin
      lvl = int'(cfg_val[CFG_LINE_THRESHOLD]) + int'($urandom_range(0, 6)) - 3;
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
      return 12'(lvl);
    end
    return r[0] ? 12'd4095 : 12'd0;
  endfunction

  // Mostly steady time steps, some long waits, a few wild jumps
  function automatic tick_t roll_tick();
    tick_t       t;
    int unsigned r;
    logic [15:0] emax;
    r = $urandom_range(0, 99);
    if (r < 3) now_ms = $urandom();
    else if (r < 8) now_ms += $urandom_range(1200, 70000);
    else if (r < 30) now_ms += $urandom_range(40, 1200);
    else now_ms += $urandom_range(0, 40);
    t.time_ms     = now_ms;
    t.left_level  = roll_level();
    t.right_level = roll_level();
    t.echo_valid  = ($urandom_range(0, 99) < 25);
    emax = cfg_val[CFG_ECHO_MAX_US];
    r = $urandom_range(0, 9);
    if (r < 5 && emax >= ECHO_MIN_US) begin
      t.echo_us = 16'($urandom_range(ECHO_MIN_US, emax));
    end else if (r < 7) begin
      case ($urandom_range(0, 3))
        0:       t.echo_us = ECHO_MIN_US - 16'd1;
        1:       t.echo_us = ECHO_MIN_US;
        2:       t.echo_us = emax;
        default: t.echo_us = emax + 16'd1;
      endcase
    end else begin
      t.echo_us = 16'($urandom_range(0, 65535));
    end
    return t;
  endfunction

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.time_ms     <= '0;
    in_ch.left_level  <= '0;
    in_ch.right_level <= '0;
    in_ch.echo_valid  <= 1'b0;
    in_ch.echo_us     <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    cfg_val = '{16'(RST_LINE_THRESHOLD), 16'(RST_BASE_SPEED), 16'(RST_TURN_SPEED),
                RST_TURN_TIME_MS, RST_DRIVE_OUT_MS, RST_DRIVE_PAST_MS,
                RST_DRIVE_IN_MS, RST_ECHO_MAX_US};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Steering: no side yet, each side, memory of the last side, both sensors
    send_fields(32'd0,  12'd0,    12'd0,    1'b0, 16'd0);
    send_fields(32'd61, 12'd4095, 12'd0,    1'b0, 16'd0);
    send_fields(32'd62, 12'd0,    12'd0,    1'b0, 16'd0);
    send_fields(32'd63, 12'd0,    12'd4095, 1'b0, 16'd0);
    send_fields(32'd64, 12'd0,    12'd0,    1'b0, 16'd0);
    send_fields(32'd65, 12'd1101, 12'd1101, 1'b0, 16'd0);
    // level at the threshold is not the line; echo without its valid flag
    send_fields(32'd66, 12'd1100, 12'd1100, 1'b0, 16'd500);
    // echo just outside the window on both ends, then at its top
    send_fields(32'd67, 12'd0, 12'd0, 1'b1, 16'd116);
    send_fields(32'd68, 12'd0, 12'd0, 1'b1, 16'd875);
    send_fields(32'd70, 12'd0, 12'd0, 1'b1, 16'd874);
    // stop hold: echo ignored, strict compare, then the full detour
    send_fields(32'd1070,  12'd0, 12'd0, 1'b1, 16'd200);
    send_fields(32'd1071,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd1722,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd2523,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd3174,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd4975,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd5626,  12'd0, 12'd0, 1'b0, 16'd0);
    // line hit while driving in returns to following
    send_fields(32'd5627,  12'd4095, 12'd0, 1'b0, 16'd0);
    // second detour, from the bottom of the echo window
    send_fields(32'd5628,  12'd0, 12'd0, 1'b1, 16'd117);
    send_fields(32'd6629,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd7280,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd8081,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd8732,  12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd10533, 12'd0, 12'd0, 1'b0, 16'd0);
    send_fields(32'd11184, 12'd0, 12'd0, 1'b0, 16'd0);
    // drive-in timeout together with a line hit goes to align
    send_fields(32'd11985, 12'd4095, 12'd4095, 1'b0, 16'd0);
    // line hit during align
    send_fields(32'd11986, 12'd0, 12'd4095, 1'b0, 16'd0);
    drain_ticks();

    // Random phases, each with its own register set and one of four idling patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: cfg_val = '{16'd2048, 16'd16500, 16'd16000, 16'd3, 16'd5, 16'd8,
                       16'd6, 16'd874};
        1: cfg_val = '{16'd4095, 16'd32767, 16'd32767, 16'd0, 16'd0, 16'd0,
                       16'd0, 16'd65535};
        2: cfg_val = '{16'd0, 16'd0, 16'd25001, 16'd65535, 16'd1, 16'd65535,
                       16'd65535, 16'd117};
        3: cfg_val = '{16'd1, 16'd25000, 16'd0, 16'd1, 16'd65535, 16'd2,
                       16'd1, 16'd0};
        default: cfg_val = '{16'd3000, 16'd12000, 16'd25000, 16'd10, 16'd20,
                             16'd30, 16'd15, 16'd500};
      endcase
      // run across the 32-bit timestamp wrap once
      if (ph == 2) now_ms = 32'hFFFF_F000;
      write_regs();
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 47; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 47; end
        default: begin send_gap_pct = 31; stall_pct = 31; end
      endcase
      repeat (PhaseTicks) send_tick(roll_tick());
      drain_ticks();
      stall_pct = 0;
    end

    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("line_follow_obstacle_sequencer verification clean");
    end else begin
      $display("line_follow_obstacle_sequencer verification failed");
    end
    $finish;
  end

endmodule
